@@ design/urfc_pkg.sv @@
`timescale 1ns / 1ps

package urfc_pkg;

    // Frame layout
    localparam int unsigned HDR_BASE       = 16;
    localparam int unsigned HDR_FULL       = 20;
    localparam int unsigned PORTS_MIN      = 24;
    localparam int unsigned DATA_MIN       = 28;
    localparam int unsigned KEEP_BYTES     = 8;
    localparam int unsigned SLOT_COUNT     = 4;
    localparam int unsigned PORT_QUERY_MAX = 4;

    localparam logic [15:0] PROTO_VER    = 16'd1001;
    localparam logic [31:0] TYPE_VERSION = 32'h0010_0000;
    localparam logic [31:0] TYPE_PORTS   = 32'h0010_0001;
    localparam logic [31:0] TYPE_DATA    = 32'h0010_0002;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // "DSUC", byte 0 in the lowest lane
    localparam logic [3:0][7:0] MAGIC = {8'h43, 8'h55, 8'h53, 8'h44};

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_CRC     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CL_VERSION = 2'd0,
        CL_PORTS   = 2'd1,
        CL_DATA    = 2'd2,
        CL_OTHER   = 2'd3
    } class_t;

    // Advance a reflected CRC-32 by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/urfc_frame_if.sv @@
`timescale 1ns / 1ps

interface urfc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ design/urfc_result_if.sv @@
`timescale 1ns / 1ps

interface urfc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  msg_class;
    logic [31:0] client_id;
    logic [2:0]  port_count;
    logic [7:0]  port_slot_a;
    logic [7:0]  port_slot_b;
    logic [7:0]  port_slot_c;
    logic [7:0]  port_slot_d;
    logic        subscribe;

    modport source (
        output valid, output status, output msg_class, output client_id,
        output port_count, output port_slot_a, output port_slot_b,
        output port_slot_c, output port_slot_d, output subscribe,
        input ready
    );
    modport sink (
        input valid, input status, input msg_class, input client_id,
        input port_count, input port_slot_a, input port_slot_b,
        input port_slot_c, input port_slot_d, input subscribe,
        output ready
    );
endinterface

@@ design/udp_request_frame_checker_top.sv @@
`timescale 1ns / 1ps
// The result for a frame is registered and is valid in the cycle after its final byte transfer.
// Throughput: one byte per cycle; the byte path and one-byte CRC stage sit between
// the frame state registers and the result register, so no byte waits on another.
// A new byte is taken whenever the result register is empty or being drained.
// Reset (rst_n, asynchronous, active low) clears the frame state and empties the result.

module udp_request_frame_checker_top
    import urfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024
)
(
    input logic          clk,
    input logic          rst_n,
    urfc_frame_if.sink   frame,
    urfc_result_if.source result
);

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (IDX_W > 17) ? IDX_W : 17;

    // Frame state
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       crc_reg, crc_next;
    logic              magic_reg, magic_next;
    logic [15:0]       version_reg, version_next;
    logic [15:0]       plen_reg, plen_next;
    logic [31:0]       claimed_reg, claimed_next;
    logic [31:0]       final_reg, final_next;
    logic [31:0]       client_reg, client_next;
    logic [31:0]       type_reg, type_next;
    logic [7:0]        pay_reg [KEEP_BYTES];
    logic [7:0]        pay_next [KEEP_BYTES];

    // Result register
    logic              out_valid_reg;
    status_t           status_reg, status_next;
    class_t            class_reg, class_next;
    logic [31:0]       client_out_reg, client_out_next;
    logic [2:0]        count_reg, count_next;
    logic [7:0]        slot_reg [PORT_QUERY_MAX];
    logic [7:0]        slot_next [PORT_QUERY_MAX];
    logic              sub_reg, sub_next;

    logic              accept;
    logic              take;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  off20;
    logic [CMP_W-1:0]  covered;
    logic [CMP_W-1:0]  n_wide;
    logic              in_cov;
    logic [7:0]        crc_data;
    logic [31:0]       crc_new;
    logic [31:0]       amount;
    logic [IDX_W-1:0]  room;
    logic [7:0]        slot_sel;
    logic              mac_ok;

    assign frame.ready = !out_valid_reg || result.ready;
    assign accept      = frame.valid && frame.ready;
    assign pos         = idx_reg;
    assign take        = idx_reg < IDX_W'(MAX_FRAME_BYTES);
    assign off20       = pos - IDX_W'(HDR_FULL);

    // Capture header and payload fields, advance CRC over the covered bytes
    always_comb
    begin
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        plen_next    = plen_reg;
        claimed_next = claimed_reg;
        final_next   = final_reg;
        client_next  = client_reg;
        type_next    = type_reg;
        for (int i = 0; i < KEEP_BYTES; i++)
        begin
            pay_next[i] = pay_reg[i];
        end
        covered  = '0;
        in_cov   = 1'b0;
        crc_data = '0;
        crc_new  = '0;

        if (take)
        begin
            if (pos < IDX_W'(4))
            begin
                if (frame.frame_byte != MAGIC[pos[1:0]])
                    magic_next = 1'b0;
            end
            else if (pos == IDX_W'(4))
                version_next[7:0] = frame.frame_byte;
            else if (pos == IDX_W'(5))
                version_next[15:8] = frame.frame_byte;
            else if (pos == IDX_W'(6))
                plen_next[7:0] = frame.frame_byte;
            else if (pos == IDX_W'(7))
                plen_next[15:8] = frame.frame_byte;
            else if (pos < IDX_W'(12))
                claimed_next[8*pos[1:0] +: 8] = frame.frame_byte;
            else if (pos < IDX_W'(16))
                client_next[8*pos[1:0] +: 8] = frame.frame_byte;
            else if (pos < IDX_W'(HDR_FULL))
                type_next[8*pos[1:0] +: 8] = frame.frame_byte;
            else if (pos < IDX_W'(HDR_FULL + KEEP_BYTES))
                pay_next[off20[2:0]] = frame.frame_byte;

            covered  = CMP_W'(HDR_BASE) + CMP_W'(plen_next);
            in_cov   = CMP_W'(pos) < covered;
            crc_data = (pos >= IDX_W'(8) && pos < IDX_W'(12)) ? 8'd0 : frame.frame_byte;
            crc_new  = crc_byte(crc_reg, crc_data);
            if (in_cov)
            begin
                crc_next = crc_new;
                if (CMP_W'(pos) + CMP_W'(1) == covered)
                    final_next = crc_new ^ ALL_ONES;
            end
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Judge the frame from the state after the final byte
    always_comb
    begin
        n_wide          = CMP_W'(idx_next);
        status_next     = ST_OK;
        class_next      = CL_OTHER;
        client_out_next = '0;
        count_next      = '0;
        sub_next        = 1'b0;
        amount          = {pay_next[3], pay_next[2], pay_next[1], pay_next[0]};
        room            = idx_next - IDX_W'(PORTS_MIN);
        slot_sel        = (pay_next[1] < 8'(SLOT_COUNT)) ? pay_next[1] : 8'd0;
        mac_ok          = pay_next[2] == 8'd0 && pay_next[3] == 8'd0 &&
                          pay_next[4] == 8'd0 && pay_next[5] == 8'd0 &&
                          pay_next[6] == 8'd0 && pay_next[7] == slot_sel + 8'd1;
        for (int i = 0; i < PORT_QUERY_MAX; i++)
        begin
            slot_next[i] = '0;
        end

        if (n_wide < CMP_W'(HDR_FULL))
            status_next = ST_SHORT;
        else if (!magic_next)
            status_next = ST_MAGIC;
        else if (version_next != PROTO_VER)
            status_next = ST_VERSION;
        else if (n_wide < CMP_W'(HDR_BASE) + CMP_W'(plen_next))
            status_next = ST_TRUNC;
        else if (claimed_next != final_next)
            status_next = ST_CRC;

        if (status_next == ST_OK)
        begin
            client_out_next = client_next;
            if (type_next == TYPE_VERSION)
                class_next = CL_VERSION;
            else if (type_next == TYPE_PORTS)
                class_next = CL_PORTS;
            else if (type_next == TYPE_DATA)
                class_next = CL_DATA;

            // Clamp slot count to four and to the slot bytes received
            if (class_next == CL_PORTS && idx_next >= IDX_W'(PORTS_MIN))
            begin
                count_next = (amount > 32'(PORT_QUERY_MAX)) ? 3'(PORT_QUERY_MAX) : amount[2:0];
                if (room < IDX_W'(count_next))
                    count_next = room[2:0];
                for (int i = 0; i < PORT_QUERY_MAX; i++)
                begin
                    if (3'(i) < count_next)
                        slot_next[i] = pay_next[4 + i];
                end
            end

            if (class_next == CL_DATA && idx_next >= IDX_W'(DATA_MIN))
            begin
                if (pay_next[0] == 8'd0 ||
                    (pay_next[0][0] && pay_next[1] < 8'(SLOT_COUNT)) ||
                    (pay_next[0][1] && mac_ok))
                    sub_next = 1'b1;
            end
        end
    end

    // Hold frame state; clear it after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= ALL_ONES;
            magic_reg     <= 1'b1;
            version_reg   <= '0;
            plen_reg      <= '0;
            claimed_reg   <= '0;
            final_reg     <= '0;
            client_reg    <= '0;
            type_reg      <= '0;
            for (int i = 0; i < KEEP_BYTES; i++)
            begin
                pay_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (frame.frame_end)
                begin
                    idx_reg     <= '0;
                    crc_reg     <= ALL_ONES;
                    magic_reg   <= 1'b1;
                    version_reg <= '0;
                    plen_reg    <= '0;
                    claimed_reg <= '0;
                    final_reg   <= '0;
                    client_reg  <= '0;
                    type_reg    <= '0;
                    for (int i = 0; i < KEEP_BYTES; i++)
                    begin
                        pay_reg[i] <= '0;
                    end
                end
                else
                begin
                    idx_reg     <= idx_next;
                    crc_reg     <= crc_next;
                    magic_reg   <= magic_next;
                    version_reg <= version_next;
                    plen_reg    <= plen_next;
                    claimed_reg <= claimed_next;
                    final_reg   <= final_next;
                    client_reg  <= client_next;
                    type_reg    <= type_next;
                    for (int i = 0; i < KEEP_BYTES; i++)
                    begin
                        pay_reg[i] <= pay_next[i];
                    end
                end
            end
            if (accept && frame.frame_end)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the result payload on the final byte transfer
    always_ff @(posedge clk)
    begin
        if (accept && frame.frame_end)
        begin
            status_reg     <= status_next;
            class_reg      <= class_next;
            client_out_reg <= client_out_next;
            count_reg      <= count_next;
            sub_reg        <= sub_next;
            for (int i = 0; i < PORT_QUERY_MAX; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = status_reg;
    assign result.msg_class   = class_reg;
    assign result.client_id   = client_out_reg;
    assign result.port_count  = count_reg;
    assign result.port_slot_a = slot_reg[0];
    assign result.port_slot_b = slot_reg[1];
    assign result.port_slot_c = slot_reg[2];
    assign result.port_slot_d = slot_reg[3];
    assign result.subscribe   = sub_reg;

endmodule

@@ design/urfc_checker.sv @@
`timescale 1ns / 1ps

module urfc_checker
    import urfc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [1:0]  msg_class,
    input logic [31:0] client_id,
    input logic [2:0]  port_count,
    input logic        subscribe
);

    // Hold a pending result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // Final byte transfer yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_end |=> out_valid)
        else $error("no result after final byte");

    // Failed frame carries no request content
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |->
        msg_class == CL_OTHER && client_id == 32'd0 && port_count == 3'd0 && !subscribe)
        else $error("failed frame with content");

    // Slot queries only on ports requests, subscribe only on data requests
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
        (port_count == 3'd0 || (msg_class == CL_PORTS && port_count <= 3'd4)) &&
        (!subscribe || msg_class == CL_DATA))
        else $error("request fields inconsistent with class");

endmodule

bind udp_request_frame_checker_top urfc_checker u_urfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (frame.valid),
    .in_ready   (frame.ready),
    .in_end     (frame.frame_end),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (result.status),
    .msg_class  (result.msg_class),
    .client_id  (result.client_id),
    .port_count (result.port_count),
    .subscribe  (result.subscribe)
);
